>>> src/rc5_etd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_etd_pkg
// Shared constants, types and helpers for the RC5 edge timing decoder.
// ----------------------------------------------------------------------------
package rc5_etd_pkg;

	localparam int FRAME_BITS = 14;
	localparam int CNT_W      = $clog2(FRAME_BITS);
	localparam int GAP_W      = 16;
	localparam int WORD_OUT_W = 14;
	// shift word covers both the frame length and the visible frame word
	localparam int WORD_W     = (FRAME_BITS > WORD_OUT_W) ? FRAME_BITS : WORD_OUT_W;
	localparam int CMD_W      = 6;
	localparam int CMD_LSB    = 8;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [GAP_W-1:0] RESTART_GAP_RST = GAP_W'(3000);
	localparam logic [GAP_W-1:0] HALF_BIT_RST    = GAP_W'(1500);
	localparam logic [CMD_W-1:0] PLAY_CMD_RST    = CMD_W'(12);

	// register index = paddr[3:2]
	localparam logic [1:0] REG_RESTART_GAP = 2'd0;
	localparam logic [1:0] REG_HALF_BIT    = 2'd1;
	localparam logic [1:0] REG_PLAY_CMD    = 2'd2;

	typedef struct packed {
		logic [GAP_W-1:0] restart_gap_us;
		logic [GAP_W-1:0] half_bit_limit_us;
		logic [CMD_W-1:0] play_cmd;
	} cfg_t;

	typedef struct packed {
		logic [WORD_OUT_W-1:0] frame_word;
		logic [CMD_W-1:0]      command_code;
		logic                  start_ok;
		logic                  is_play;
	} result_t;

	function automatic logic [CMD_W-1:0] reverse_cmd(input logic [CMD_W-1:0] v);
		logic [CMD_W-1:0] r;
		for (int i = 0; i < CMD_W; i++) begin
			r[CMD_W-1-i] = v[i];
		end
		return r;
	endfunction

endpackage

>>> src/rc5_etd_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_etd_apb_regs
// APB register file holding the decoder timing limits and the play code.
// ----------------------------------------------------------------------------
module rc5_etd_apb_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rc5_etd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rc5_etd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rc5_etd_pkg::APB_DATA_W-1:0] prdata,
	output logic                               pready,
	output rc5_etd_pkg::cfg_t                  cfg
);
	import rc5_etd_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.restart_gap_us    <= RESTART_GAP_RST;
			cfg_q.half_bit_limit_us <= HALF_BIT_RST;
			cfg_q.play_cmd          <= PLAY_CMD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RESTART_GAP: cfg_q.restart_gap_us    <= pwdata[GAP_W-1:0];
				REG_HALF_BIT:    cfg_q.half_bit_limit_us <= pwdata[GAP_W-1:0];
				REG_PLAY_CMD:    cfg_q.play_cmd          <= pwdata[CMD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RESTART_GAP: prdata = APB_DATA_W'(cfg_q.restart_gap_us);
			REG_HALF_BIT:    prdata = APB_DATA_W'(cfg_q.half_bit_limit_us);
			REG_PLAY_CMD:    prdata = APB_DATA_W'(cfg_q.play_cmd);
			default:         prdata = '0;
		endcase
	end

endmodule

>>> src/rc5_etd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_etd_core
// Edge input register, frame state and the per-edge decode step.
// ----------------------------------------------------------------------------
module rc5_etd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rc5_etd_pkg::cfg_t             cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_rise,
	input  logic [rc5_etd_pkg::GAP_W-1:0] in_interval,
	output logic                          res_valid,
	input  logic                          res_ready,
	output rc5_etd_pkg::result_t          res
);
	import rc5_etd_pkg::*;

	logic                  valid_s1;
	logic                  rise_s1;
	logic [GAP_W-1:0]      interval_s1;

	logic [WORD_W-1:0]     word_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;

	logic                  advance;
	logic                  short_gap;
	logic                  last_bit;
	logic                  skip;
	logic                  new_bit;
	logic [WORD_W-1:0]     word_base;
	logic [CNT_W-1:0]      cnt_base;
	logic [WORD_W-1:0]     word_new;
	logic                  done;
	logic [CMD_W-1:0]      cmd;

	// stage advances whenever the result register can take a request
	assign advance  = res_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rise_s1     <= in_rise;
			interval_s1 <= in_interval;
		end
	end

	assign short_gap = interval_s1 < cfg.half_bit_limit_us;
	assign last_bit  = (cnt_q != '0) && word_q[cnt_q - CNT_W'(1)];

	always_comb begin
		word_base = word_q;
		cnt_base  = cnt_q;
		new_bit   = !rise_s1;
		skip      = 1'b0;
		if (!rise_s1) begin
			if (!busy_q || interval_s1 > cfg.restart_gap_us) begin
				word_base = '0;
				cnt_base  = '0;
			end else if (!last_bit && short_gap) begin
				skip = 1'b1;
			end
		end else begin
			// a rise outside a frame, or a repeated 1 inside half a bit, is mid-bit
			if (!busy_q || (last_bit && short_gap)) begin
				skip = 1'b1;
			end
		end
	end

	assign word_new = word_base | (WORD_W'(new_bit) << cnt_base);
	assign done     = cnt_base == CNT_W'(FRAME_BITS - 1);
	assign cmd      = reverse_cmd(word_new[CMD_LSB +: CMD_W]);

	assign res_valid        = valid_s1 && !skip && done;
	assign res.frame_word   = word_new[WORD_OUT_W-1:0];
	assign res.command_code = cmd;
	assign res.start_ok     = word_new[0] & word_new[1];
	assign res.is_play      = cmd == cfg.play_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (valid_s1 && advance && !skip) begin
			if (done) begin
				word_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b0;
			end else begin
				word_q <= word_new;
				cnt_q  <= cnt_base + CNT_W'(1);
				busy_q <= 1'b1;
			end
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cnt_q == '0 && word_q == '0))
		else $error("idle decoder holds stale frame state");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> !busy_q)
		else $error("decoder still busy after frame completion");

	a_busy_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0 && word_q[0]))
		else $error("active frame lacks its leading 1 bit");

	a_no_emit_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> ($stable(cnt_q) && $stable(busy_q)))
		else $error("frame state moved while stage stalled");

endmodule

>>> src/rc5_etd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_etd_out_reg
// Result register feeding the master stream port.
// ----------------------------------------------------------------------------
module rc5_etd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	output logic                 res_ready,
	input  rc5_etd_pkg::result_t res,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rc5_etd_pkg::result_t out_res
);
	import rc5_etd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

>>> src/rc5_edge_timing_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_edge_timing_decoder
// RC5 infrared decoder working on edge polarity and inter-edge time.
// ----------------------------------------------------------------------------
// An edge that completes a frame passes the edge register, then the result
// register. Throughput: one edge per cycle unless m_tready stalls the output;
// the decode step is a compare and a shift.
// Reset: arst_n clears the frame state to idle and loads the default limits
// (restart gap 3000 us, half bit 1500 us, play code 12).
module rc5_edge_timing_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rc5_etd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [rc5_etd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [rc5_etd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                pready,
	// edge stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rc5_etd_pkg::IN_TDATA_W-1:0]  s_tdata,  // [15:0] interval_us
	input  logic                                s_tuser,  // [0] edge_is_rise
	// frame stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [13:0] frame_word, [19:14] command_code, [20] start_ok, [21] is_play,
	// [23:22] zero
	output logic [rc5_etd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import rc5_etd_pkg::*;

	cfg_t    cfg;
	result_t core_res;
	result_t out_res;
	logic    core_valid;
	logic    core_ready;

	rc5_etd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rc5_etd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_rise     (s_tuser),
		.in_interval (s_tdata[GAP_W-1:0]),
		.res_valid   (core_valid),
		.res_ready   (core_ready),
		.res         (core_res)
	);

	rc5_etd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (core_valid),
		.res_ready (core_ready),
		.res       (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {2'b00, out_res.is_play, out_res.start_ok,
		out_res.command_code, out_res.frame_word};

endmodule

>>> tb/rc5_edge_timing_decoder_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_edge_timing_decoder_chk
// Passive checker: watches the APB port and both streams, decodes every
// accepted edge into its own frame state, queues the frames that must come
// out and compares each delivered frame field by field. Register reads are
// checked against the tracked settings.
// ----------------------------------------------------------------------------
module rc5_edge_timing_decoder_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rc5_etd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [rc5_etd_pkg::APB_DATA_W-1:0]  pwdata,
	input  logic [rc5_etd_pkg::APB_DATA_W-1:0]  prdata,
	input  logic                                pready,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [rc5_etd_pkg::IN_TDATA_W-1:0]  s_tdata,  // [15:0] interval_us
	input  logic                                s_tuser,  // [0] edge_is_rise
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// [13:0] frame_word, [19:14] command_code, [20] start_ok, [21] is_play,
	// [23:22] zero
	input  logic [rc5_etd_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int unsigned                         errors,
	output int unsigned                         pending
);

	import rc5_etd_pkg::*;

	localparam int START_OK_BIT = WORD_OUT_W + CMD_W;
	localparam int PLAY_BIT     = START_OK_BIT + 1;
	localparam int PAD_LSB      = PLAY_BIT + 1;

	logic [GAP_W-1:0]      restart_gap;
	logic [GAP_W-1:0]      half_bit;
	logic [CMD_W-1:0]      play_val;
	logic [WORD_W-1:0]     rx_word;
	int unsigned           rx_count;
	logic                  in_frame;
	result_t               frames_due[$];
	int unsigned           err_cnt = 0;

	task automatic report(input string what, input int unsigned want, input int unsigned got);
		if (err_cnt < 40)
			$display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
		err_cnt++;
	endtask

	task automatic take_bit(input logic b);
		result_t r;
		int      i;
		rx_word[rx_count] = b;
		rx_count++;
		if (rx_count == FRAME_BITS) begin
			r.frame_word = rx_word[WORD_OUT_W-1:0];
			for (i = 0; i < CMD_W; i++)
				r.command_code[CMD_W-1-i] = rx_word[CMD_LSB+i];
			r.start_ok = rx_word[0] & rx_word[1];
			r.is_play  = (r.command_code == play_val);
			frames_due.push_back(r);
			rx_word  = '0;
			rx_count = 0;
			in_frame = 1'b0;
		end
	endtask

	task automatic decode_edge(input logic rise, input logic [GAP_W-1:0] gap);
		logic short_gap;
		logic prev;
		short_gap = (gap < half_bit);
		prev      = (rx_count == 0) ? 1'b0 : rx_word[rx_count-1];
		if (!rise) begin
			if (!in_frame || gap > restart_gap) begin
				rx_word  = '0;
				rx_count = 0;
				in_frame = 1'b1;
				take_bit(1'b1);
			end else if (!(prev == 1'b0 && short_gap)) begin
				take_bit(1'b1);
			end
		end else if (in_frame && !(rx_count != 0 && prev && short_gap)) begin
			take_bit(1'b0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t                 r;
		logic [APB_DATA_W-1:0]   want;
		if (!arst_n) begin
			restart_gap = RESTART_GAP_RST;
			half_bit    = HALF_BIT_RST;
			play_val    = PLAY_CMD_RST;
			rx_word     = '0;
			rx_count    = 0;
			in_frame    = 1'b0;
			frames_due.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[APB_ADDR_W-1:2])
						REG_RESTART_GAP: restart_gap = pwdata[GAP_W-1:0];
						REG_HALF_BIT:    half_bit    = pwdata[GAP_W-1:0];
						REG_PLAY_CMD:    play_val    = pwdata[CMD_W-1:0];
						default: ;
					endcase
				end else begin
					case (paddr[APB_ADDR_W-1:2])
						REG_RESTART_GAP: want = APB_DATA_W'(restart_gap);
						REG_HALF_BIT:    want = APB_DATA_W'(half_bit);
						REG_PLAY_CMD:    want = APB_DATA_W'(play_val);
						default:         want = '0;
					endcase
					if (prdata !== want)
						report("register read", want, prdata);
				end
			end

			if (s_tvalid && s_tready)
				decode_edge(s_tuser, s_tdata[GAP_W-1:0]);

			if (m_tvalid && m_tready) begin
				if (frames_due.size() == 0) begin
					report("unrequested frame", 0, m_tdata);
				end else begin
					r = frames_due.pop_front();
					if (m_tdata[WORD_OUT_W-1:0] !== r.frame_word)
						report("frame_word", r.frame_word, m_tdata[WORD_OUT_W-1:0]);
					if (m_tdata[WORD_OUT_W +: CMD_W] !== r.command_code)
						report("command_code", r.command_code, m_tdata[WORD_OUT_W +: CMD_W]);
					if (m_tdata[START_OK_BIT] !== r.start_ok)
						report("start_ok", r.start_ok, m_tdata[START_OK_BIT]);
					if (m_tdata[PLAY_BIT] !== r.is_play)
						report("is_play", r.is_play, m_tdata[PLAY_BIT]);
					if (m_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
						report("pad bits", 0, m_tdata[OUT_TDATA_W-1:PAD_LSB]);
				end
			end

			errors  <= err_cnt;
			pending <= frames_due.size();
		end
	end

endmodule

>>> tb/rc5_edge_timing_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_edge_timing_decoder_tb
// Drives the RC5 edge decoder with boundary edges, well-formed Manchester
// frames with random content, truncated frames and random edges, under
// several register settings and random stalls on both streams. Checking is
// done by the checker instance; this module only stimulates and judges.
// ----------------------------------------------------------------------------
module rc5_edge_timing_decoder_tb;

	import rc5_etd_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int EDGES_PER_PHASE = 206;
	localparam int NUM_PHASES      = 8;
	localparam int GAP_MAX         = (1 << GAP_W) - 1;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;  // [15:0] interval_us
	logic                   s_tuser = 1'b0;  // [0] edge_is_rise
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [13:0] frame_word, [19:14] command_code, [20] start_ok, [21] is_play,
	// [23:22] zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	int unsigned chk_errors;
	int unsigned chk_pending;

	logic        calm = 1'b0;
	int unsigned edge_cnt = 0;
	int unsigned stall_left = 0;
	int unsigned stuck_cycles = 0;

	// settings as last written, used to shape the edge timing
	int unsigned restart_gap = RESTART_GAP_RST;
	int unsigned half_bit = HALF_BIT_RST;
	int unsigned play_val = PLAY_CMD_RST;

	always #6 clk = ~clk;

	rc5_edge_timing_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	rc5_edge_timing_decoder_chk chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(chk_errors), .pending(chk_pending)
	);

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// mostly near the low end of the window, like real bit timing
	function automatic logic [GAP_W-1:0] pick_gap(input int unsigned lo, input int unsigned hi);
		if (lo > GAP_MAX)
			lo = GAP_MAX;
		if (hi > GAP_MAX)
			hi = GAP_MAX;
		if (lo >= hi)
			return GAP_W'(lo);
		if ($urandom_range(0, 3) != 0 && hi - lo > 600)
			hi = lo + 600;
		return GAP_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [WORD_W-1:0] make_word(input bit hit_play);
		logic [WORD_W-1:0] w;
		int                i;
		w = WORD_W'($urandom);
		w[0] = 1'b1;
		if ($urandom_range(0, 4) != 0)
			w[1] = 1'b1;
		if (hit_play) begin
			for (i = 0; i < CMD_W; i++)
				w[CMD_LSB+i] = play_val[CMD_W-1-i];
		end
		return w;
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin : pick_stall
			int unsigned n;
			n = idle_len();
			m_tready <= (n == 0);
			stall_left <= (n == 0) ? 0 : n - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles == WATCHDOG_LIMIT) begin
				$display("rc5_edge_timing_decoder_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [1:0] idx, input int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned val);
		apb_access(1'b1, idx, val);
		case (idx)
			REG_RESTART_GAP: restart_gap = val & GAP_MAX;
			REG_HALF_BIT:    half_bit    = val & GAP_MAX;
			REG_PLAY_CMD:    play_val    = val & ((1 << CMD_W) - 1);
			default: ;
		endcase
	endtask

	task automatic read_back();
		apb_access(1'b0, REG_RESTART_GAP, 0);
		apb_access(1'b0, REG_HALF_BIT, 0);
		apb_access(1'b0, REG_PLAY_CMD, 0);
	endtask

	task automatic send_edge(input logic rise, input logic [GAP_W-1:0] gap, input bit tally);
		int unsigned n;
		n = idle_len();
		if (n != 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rise;
		s_tdata  <= gap;
		do @(posedge clk); while (!s_tready);
		if (tally)
			edge_cnt++;
	endtask

	// Manchester-style edges: a bit equal to the last one may get a skipped
	// mid-bit edge in front of it; a changed bit needs a full-length gap.
	task automatic send_frame(input logic [WORD_W-1:0] w, input int nbits, input int skip_pct);
		logic        prev;
		logic        b;
		int          i;
		int unsigned lim;
		prev = 1'b1;
		send_edge(1'b0, (restart_gap < GAP_MAX) ? pick_gap(restart_gap + 1, GAP_MAX)
			: GAP_W'(GAP_MAX), 1'b1);
		for (i = 1; i < nbits; i++) begin
			b = w[i];
			if (b == prev) begin
				if (half_bit != 0 && $urandom_range(0, 99) < skip_pct) begin
					lim = (half_bit - 1 < restart_gap) ? half_bit - 1 : restart_gap;
					if (b)
						send_edge(1'b1, GAP_W'($urandom_range(0, half_bit - 1)), 1'b1);
					else
						send_edge(1'b0, GAP_W'($urandom_range(0, lim)), 1'b1);
				end
				if (b)
					send_edge(1'b0, pick_gap(0, restart_gap), 1'b1);
				else
					send_edge(1'b1, pick_gap(0, GAP_MAX), 1'b1);
			end else begin
				if (b)
					send_edge(1'b0, pick_gap(half_bit, restart_gap), 1'b1);
				else
					send_edge(1'b1, pick_gap(half_bit, GAP_MAX), 1'b1);
			end
			prev = b;
		end
	endtask

	// lets the last frame out and the edge pipeline empty before a register write
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (chk_pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic configure(input int phase);
		int unsigned g;
		case (phase)
			0: ;
			1: begin
				write_reg(REG_RESTART_GAP, 32'(RESTART_GAP_RST));
				write_reg(REG_HALF_BIT, 32'(HALF_BIT_RST));
				write_reg(REG_PLAY_CMD, $urandom_range(0, 63));
			end
			2: begin
				write_reg(REG_RESTART_GAP, GAP_MAX);
				write_reg(REG_HALF_BIT, GAP_MAX);
				write_reg(REG_PLAY_CMD, 63);
			end
			3: begin
				write_reg(REG_RESTART_GAP, 0);
				write_reg(REG_HALF_BIT, 0);
				write_reg(REG_PLAY_CMD, 0);
			end
			4: begin
				// half-bit limit above the restart gap
				write_reg(REG_RESTART_GAP, 1000);
				write_reg(REG_HALF_BIT, 1200);
				write_reg(REG_PLAY_CMD, $urandom_range(0, 63));
			end
			default: begin
				g = $urandom_range(1500, 9000);
				write_reg(REG_RESTART_GAP, g);
				write_reg(REG_HALF_BIT, $urandom_range(100, g));
				write_reg(REG_PLAY_CMD, $urandom_range(0, 63));
			end
		endcase
		read_back();
	endtask

	initial begin : stimulus
		int          phase;
		int unsigned target;
		int unsigned r;
		int unsigned k;
		logic        rise;
		logic [GAP_W-1:0] g;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_back();

		// rises while idle are dropped
		send_edge(1'b1, '0, 1'b0);
		send_edge(1'b1, GAP_W'(GAP_MAX), 1'b0);
		// gaps equal to the limits, then one just above the restart gap
		send_edge(1'b0, GAP_W'(GAP_MAX), 1'b1);
		send_edge(1'b1, HALF_BIT_RST, 1'b1);
		send_edge(1'b0, GAP_W'(HALF_BIT_RST - 1), 1'b1);
		send_edge(1'b0, RESTART_GAP_RST, 1'b1);
		send_edge(1'b0, GAP_W'(RESTART_GAP_RST + 1), 1'b1);
		send_edge(1'b1, '0, 1'b1);
		// full frame matching the play code
		send_frame(make_word(1'b1), FRAME_BITS, 0);
		settle();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			configure(phase);
			target = edge_cnt + EDGES_PER_PHASE;
			while (edge_cnt < target) begin
				if ($urandom_range(0, 49) == 0)
					calm <= !calm;
				r = $urandom_range(0, 99);
				if (r < 78) begin
					send_frame(make_word($urandom_range(0, 3) == 0), FRAME_BITS, 60);
				end else if (r < 88) begin
					send_frame(make_word(1'b0), $urandom_range(1, FRAME_BITS - 1), 60);
				end else begin
					k = $urandom_range(1, 4);
					repeat (k) begin
						rise = 1'($urandom_range(0, 1));
						case ($urandom_range(0, 3))
							0:       g = '0;
							1:       g = GAP_W'(GAP_MAX);
							default: g = GAP_W'($urandom_range(0, GAP_MAX));
						endcase
						send_edge(rise, g, !rise);
					end
				end
			end
			settle();
		end

		if (chk_errors == 0 && chk_pending == 0)
			$display("rc5_edge_timing_decoder_tb OK");
		else
			$display("rc5_edge_timing_decoder_tb NOT OK");
		$finish;
	end

endmodule
